// ===== src/mcrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcrf_pkg
// types, command codes and saturating helpers of the range filter
// ----------------------------------------------------------------------------
package mcrf_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 8;
  localparam int VALUE_W  = 32;
  localparam int ROW_W    = 10;
  localparam int COL_W    = 3;
  localparam int CMD_W    = 4;
  localparam int CNT_W    = 11;
  localparam int CCNT_W   = 4;
  localparam int WORD_W   = MAX_COLS * VALUE_W;

  typedef logic signed [VALUE_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam logic [CMD_W-1:0] CMD_LOAD      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SET_MIN   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_SET_MAX   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SET_LOW   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SET_HIGH  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_MOVE      = 4'd5;
  localparam logic [CMD_W-1:0] CMD_MOVE_LOW  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_MOVE_HIGH = 4'd7;
  localparam logic [CMD_W-1:0] CMD_RESET_COL = 4'd8;
  localparam logic [CMD_W-1:0] CMD_RESET_ALL = 4'd9;
  localparam logic [CMD_W-1:0] CMD_READ      = 4'd10;

  typedef enum logic [2:0] {
    BOP_NONE,
    BOP_PREP,
    BOP_LOW_CAND,
    BOP_LOW_SET,
    BOP_HIGH_CAND,
    BOP_HIGH_SET,
    BOP_LOAD,
    BOP_RESET_ALL
  } bop_t;

  typedef struct packed {
    bop_t             op;
    logic [CMD_W-1:0] cmd;
    logic [COL_W-1:0] col;
    val_t             value;
  } bnd_req_t;

  // saturating a + b or a - b
  function automatic val_t sat_sum(val_t a, val_t b, logic sub);
    logic signed [VALUE_W:0] s;
    s = sub ? ({a[VALUE_W-1], a} - {b[VALUE_W-1], b})
            : ({a[VALUE_W-1], a} + {b[VALUE_W-1], b});
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      return s[VALUE_W] ? VAL_MIN : VAL_MAX;
    end
    return s[VALUE_W-1:0];
  endfunction

  // upper bound wins when the bounds cross
  function automatic val_t clamp(val_t x, val_t lo, val_t hi);
    val_t t;
    t = (x < lo) ? lo : x;
    return (t > hi) ? hi : t;
  endfunction

endpackage

// ===== src/mcrf_ram.sv =====
// ----------------------------------------------------------------------------
// mcrf_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
module mcrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mcrf_bounds.sv =====
// ----------------------------------------------------------------------------
// mcrf_bounds
// per-column limits and selection ranges with the clamped update steps
// ----------------------------------------------------------------------------
module mcrf_bounds (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mcrf_pkg::bnd_req_t                   req,
  output mcrf_pkg::val_t [mcrf_pkg::MAX_COLS-1:0] low_o,
  output mcrf_pkg::val_t [mcrf_pkg::MAX_COLS-1:0] high_o,
  output mcrf_pkg::val_t [mcrf_pkg::MAX_COLS-1:0] min_o,
  output mcrf_pkg::val_t [mcrf_pkg::MAX_COLS-1:0] max_o
);
  import mcrf_pkg::*;

  val_t [MAX_COLS-1:0] low_r, low_nxt, high_r, high_nxt;
  val_t [MAX_COLS-1:0] min_r, min_nxt, max_r, max_nxt;
  val_t w_r, w_nxt, cand_r, cand_nxt;
  logic gt_r, gt_nxt, lt_r, lt_nxt;

  val_t lo, hi, cmin, cmax, v;
  logic signed [VALUE_W:0] sum_hi, sum_lo;

  assign lo   = low_r[req.col];
  assign hi   = high_r[req.col];
  assign cmin = min_r[req.col];
  assign cmax = max_r[req.col];
  assign v    = req.value;

  assign sum_hi = {hi[VALUE_W-1], hi} + {v[VALUE_W-1], v};
  assign sum_lo = {lo[VALUE_W-1], lo} + {v[VALUE_W-1], v};

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    w_nxt    = w_r;
    cand_nxt = cand_r;
    gt_nxt   = gt_r;
    lt_nxt   = lt_r;
    unique case (req.op)
      BOP_PREP: begin
        w_nxt  = sat_sum(hi, lo, 1'b1);
        gt_nxt = sum_hi > $signed({cmax[VALUE_W-1], cmax});
        lt_nxt = sum_lo < $signed({cmin[VALUE_W-1], cmin});
      end
      BOP_LOW_CAND: begin
        case (req.cmd)
          CMD_MOVE: begin
            if (gt_r) cand_nxt = sat_sum(cmax, w_r, 1'b1);
            else if (lt_r) cand_nxt = cmin;
            else cand_nxt = sat_sum(lo, v, 1'b0);
          end
          CMD_MOVE_LOW:  cand_nxt = sat_sum(lo, v, 1'b0);
          CMD_RESET_COL: cand_nxt = cmin;
          default:       cand_nxt = v;
        endcase
      end
      BOP_LOW_SET: begin
        if (req.cmd == CMD_SET_MIN) begin
          if (v > lo) low_nxt[req.col] = clamp(cand_r, cmin, hi);
          min_nxt[req.col] = v;
        end else if (req.cmd == CMD_SET_LOW || req.cmd == CMD_MOVE ||
                     req.cmd == CMD_MOVE_LOW || req.cmd == CMD_RESET_COL) begin
          low_nxt[req.col] = clamp(cand_r, cmin, hi);
        end
      end
      BOP_HIGH_CAND: begin
        case (req.cmd)
          CMD_MOVE: begin
            if (gt_r) cand_nxt = cmax;
            else if (lt_r) cand_nxt = sat_sum(cmin, w_r, 1'b0);
            else cand_nxt = sat_sum(hi, v, 1'b0);
          end
          CMD_MOVE_HIGH: cand_nxt = sat_sum(hi, v, 1'b0);
          CMD_RESET_COL: cand_nxt = cmax;
          default:       cand_nxt = v;
        endcase
      end
      BOP_HIGH_SET: begin
        if (req.cmd == CMD_SET_MAX) begin
          if (v < hi) high_nxt[req.col] = clamp(cand_r, lo, cmax);
          max_nxt[req.col] = v;
        end else if (req.cmd == CMD_SET_HIGH || req.cmd == CMD_MOVE ||
                     req.cmd == CMD_MOVE_HIGH || req.cmd == CMD_RESET_COL) begin
          high_nxt[req.col] = clamp(cand_r, lo, cmax);
        end
      end
      BOP_LOAD: begin
        min_nxt[req.col]  = (v < cmin) ? v : cmin;
        max_nxt[req.col]  = (v > cmax) ? v : cmax;
        low_nxt[req.col]  = (v < cmin) ? v : cmin;
        high_nxt[req.col] = (v > cmax) ? v : cmax;
      end
      BOP_RESET_ALL: begin
        low_nxt  = min_r;
        high_nxt = max_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        low_r[j]  <= VAL_MAX;
        high_r[j] <= VAL_MIN;
        min_r[j]  <= VAL_MAX;
        max_r[j]  <= VAL_MIN;
      end
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      min_r  <= min_nxt;
      max_r  <= max_nxt;
    end
    w_r    <= w_nxt;
    cand_r <= cand_nxt;
    gt_r   <= gt_nxt;
    lt_r   <= lt_nxt;
  end

  assign low_o  = low_r;
  assign high_o = high_r;
  assign min_o  = min_r;
  assign max_o  = max_r;

endmodule

// ===== src/multi_column_range_filter.sv =====
// ----------------------------------------------------------------------------
// multi_column_range_filter
// range brushing over a table of signed cells with per-row selected flags
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | command, row, column, operand
// out_    | output    | out_valid/out_stall| row_selected, ranges, limits, rows
//
// one request at a time; load, reset all and bound updates (set min, max, low, high,
// move, move low/high, reset column) rescan the table before giving the result;
// read row and unknown codes only read the row flag
// the rescan reads one full table row (all columns in one wide word) per cycle
// reset clears counts, limits and ranges; cell and flag memories need no clear
// a stalled result holds in the output register while the next request is taken
// ----------------------------------------------------------------------------
module multi_column_range_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mcrf_pkg::CMD_W-1:0]        in_command,
  input  logic [mcrf_pkg::ROW_W-1:0]        in_row,
  input  logic [mcrf_pkg::COL_W-1:0]        in_column,
  input  logic signed [mcrf_pkg::VALUE_W-1:0] in_operand,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_row_selected,
  output logic signed [mcrf_pkg::VALUE_W-1:0] out_range_low,
  output logic signed [mcrf_pkg::VALUE_W-1:0] out_range_high,
  output logic signed [mcrf_pkg::VALUE_W-1:0] out_limit_low,
  output logic signed [mcrf_pkg::VALUE_W-1:0] out_limit_high,
  output logic [mcrf_pkg::CNT_W-1:0]        out_rows_in_use
);
  import mcrf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOW_CAND,
    ST_LOW_SET,
    ST_HIGH_CAND,
    ST_HIGH_SET,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_ALL,
    ST_SCAN,
    ST_FLAG_RD,
    ST_DONE
  } state_t;

  state_t state_r;

  // latched request
  logic [CMD_W-1:0] cmd_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  val_t             val_r;

  logic [CNT_W-1:0]  row_count_r;
  logic [CCNT_W-1:0] col_count_r;

  // rescan pipeline: issue counter, then the registered ram read (pv_r, paddr_r)
  logic [CNT_W-1:0] issue_r;
  logic             pv_r;
  logic [ROW_W-1:0] paddr_r;

  logic out_valid_r, out_sel_r;
  val_t out_rlo_r, out_rhi_r, out_llo_r, out_lhi_r;
  logic [CNT_W-1:0] out_rows_r;

  bnd_req_t breq;
  val_t [MAX_COLS-1:0] low_w, high_w, min_w, max_w;

  logic [ROW_W-1:0]  cell_raddr;
  logic [WORD_W-1:0] cell_rdata, cell_wdata;
  logic              cell_we;
  logic              flag_rdata, row_flag;
  logic              in_acc, out_free, issue_more;
  logic [MAX_COLS-1:0] col_ok;

  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !(out_valid_r && out_stall);
  assign issue_more = issue_r < row_count_r;

  // bound unit step follows the state
  always_comb begin
    breq.cmd   = cmd_r;
    breq.col   = col_r;
    breq.value = val_r;
    unique case (state_r)
      ST_PREP:      breq.op = BOP_PREP;
      ST_LOW_CAND:  breq.op = BOP_LOW_CAND;
      ST_LOW_SET:   breq.op = BOP_LOW_SET;
      ST_HIGH_CAND: breq.op = BOP_HIGH_CAND;
      ST_HIGH_SET:  breq.op = BOP_HIGH_SET;
      ST_LOAD_WR:   breq.op = BOP_LOAD;
      ST_ALL:       breq.op = BOP_RESET_ALL;
      default:      breq.op = BOP_NONE;
    endcase
  end

  mcrf_bounds u_bounds (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (breq),
    .low_o  (low_w),
    .high_o (high_w),
    .min_o  (min_w),
    .max_o  (max_w)
  );

  // cell memory: one word per table row, all columns side by side
  assign cell_raddr = (state_r == ST_SCAN) ? issue_r[ROW_W-1:0] : row_r;
  assign cell_we    = (state_r == ST_LOAD_WR);

  always_comb begin
    cell_wdata = cell_rdata;
    cell_wdata[col_r*VALUE_W +: VALUE_W] = val_r;
  end

  mcrf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ROWS)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (row_r),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  // a row is selected when every column in use holds its cell in range
  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      col_ok[j] = (CCNT_W'(j) >= col_count_r) ||
                  (($signed(cell_rdata[j*VALUE_W +: VALUE_W]) >= low_w[j]) &&
                   ($signed(cell_rdata[j*VALUE_W +: VALUE_W]) <= high_w[j]));
    end
    row_flag = &col_ok;
  end

  mcrf_ram #(.WIDTH(1), .DEPTH(MAX_ROWS)) u_flags (
    .clk   (clk),
    .we    (state_r == ST_SCAN && pv_r),
    .waddr (paddr_r),
    .wdata (row_flag),
    .raddr (row_r),
    .rdata (flag_rdata)
  );

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_count_r <= '0;
      col_count_r <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // taken result drops unless a new one is loaded in the same cycle
      if (out_valid_r && !out_stall && state_r != ST_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_command;
            row_r <= in_row;
            col_r <= in_column;
            val_r <= in_operand;
            if (in_command == CMD_LOAD) begin
              state_r <= ST_LOAD_RD;
            end else if (in_command == CMD_RESET_ALL) begin
              state_r <= ST_ALL;
            end else if (in_command >= CMD_SET_MIN && in_command <= CMD_RESET_COL) begin
              state_r <= ST_PREP;
            end else begin
              state_r <= ST_FLAG_RD;
            end
          end
        end
        ST_PREP:      state_r <= ST_LOW_CAND;
        ST_LOW_CAND:  state_r <= ST_LOW_SET;
        ST_LOW_SET:   state_r <= ST_HIGH_CAND;
        ST_HIGH_CAND: state_r <= ST_HIGH_SET;
        ST_HIGH_SET: begin
          state_r <= ST_SCAN;
          issue_r <= '0;
          pv_r    <= 1'b0;
        end
        ST_LOAD_RD: state_r <= ST_LOAD_WR;
        ST_LOAD_WR: begin
          if ({1'b0, row_r} >= row_count_r) row_count_r <= {1'b0, row_r} + 1'b1;
          if ({1'b0, col_r} >= col_count_r) col_count_r <= {1'b0, col_r} + 1'b1;
          state_r <= ST_SCAN;
          issue_r <= '0;
          pv_r    <= 1'b0;
        end
        ST_ALL: begin
          state_r <= ST_SCAN;
          issue_r <= '0;
          pv_r    <= 1'b0;
        end
        ST_SCAN: begin
          pv_r    <= issue_more;
          paddr_r <= issue_r[ROW_W-1:0];
          if (issue_more) issue_r <= issue_r + 1'b1;
          if (!issue_more && !pv_r) state_r <= ST_FLAG_RD;
        end
        ST_FLAG_RD: state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_sel_r   <= ({1'b0, row_r} < row_count_r) && flag_rdata;
            out_rlo_r   <= low_w[col_r];
            out_rhi_r   <= high_w[col_r];
            out_llo_r   <= min_w[col_r];
            out_lhi_r   <= max_w[col_r];
            out_rows_r  <= row_count_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_selected = out_sel_r;
  assign out_range_low    = out_rlo_r;
  assign out_range_high   = out_rhi_r;
  assign out_limit_low    = out_llo_r;
  assign out_limit_high   = out_lhi_r;
  assign out_rows_in_use  = out_rows_r;

endmodule
